// ===== sv/vnat_pkg.sv =====
// Shared constants and types for the vertex/normal affine transform pipeline.
package vnat_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int COEF_INT_BITS   = 4;
   localparam int COORD_FRAC      = 16;
   localparam int NORM_ONE        = 1 << COORD_FRAC;

   // renormalization datapath: largest component scaled to [2^29, 2^30)
   localparam int W_BITS    = 30;
   localparam int SQ_BITS   = 2 * W_BITS + 2;
   localparam int ROOT_BITS = SQ_BITS / 2;
   localparam int Q_BITS    = COORD_FRAC + 1;
   localparam int NUM_BITS  = W_BITS + COORD_FRAC + 1;

   localparam int NORM_MIN_SQ = 43;
   localparam int SMALL_LIMIT = 8;
   localparam int SMALL_BITS  = 3;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_X,
      CSR_ROW_Y,
      CSR_ROW_Z,
      CSR_SHIFT_X,
      CSR_SHIFT_Y,
      CSR_SHIFT_Z
   } csr_index_type;

   localparam logic OP_POSITION = 1'b0;
   localparam logic OP_NORMAL   = 1'b1;

   typedef struct packed {
      logic valid;
      logic op;
      logic renorm;
   } stage_ctl_type;

endpackage

// ===== sv/vnat_norm_pipe.sv =====
// Pipelined square root and three-lane restoring divide for normal renormalization.
module vnat_norm_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  vnat_pkg::stage_ctl_type                       in_ctl,
   input  logic [SIDE_W-1:0]                             in_side,
   input  logic [3*vnat_pkg::W_BITS-1:0]                 in_w,
   input  logic [vnat_pkg::SQ_BITS-1:0]                  in_sq,
   output vnat_pkg::stage_ctl_type                       out_ctl,
   output logic [SIDE_W-1:0]                             out_side,
   output logic [3*vnat_pkg::Q_BITS-1:0]                 out_q
);
   import vnat_pkg::*;

   localparam int REM_W = ROOT_BITS + 2;
   localparam int DIV_W = ROOT_BITS + 1;

   // square root: one result bit per stage
   stage_ctl_type          sq_ctl_ff  [ROOT_BITS];
   logic [SIDE_W-1:0]      sq_side_ff [ROOT_BITS];
   logic [3*W_BITS-1:0]    sq_w_ff    [ROOT_BITS];
   logic [SQ_BITS-1:0]     sq_rad_ff  [ROOT_BITS];
   logic [REM_W-1:0]       sq_rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   sq_root_ff [ROOT_BITS];

   genvar k;
   for (k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      stage_ctl_type        ctl_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [3*W_BITS-1:0]  w_prev;
      logic [SQ_BITS-1:0]   rad_prev;
      logic [REM_W-1:0]     rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_W-1:0]     rem_t;
      logic [REM_W-1:0]     trial;
      logic [REM_W-1:0]     rem_in;
      logic [ROOT_BITS-1:0] root_in;
      logic                 ge;

      if (k == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign side_prev = in_side;
         assign w_prev    = in_w;
         assign rad_prev  = in_sq;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign ctl_prev  = sq_ctl_ff[k-1];
         assign side_prev = sq_side_ff[k-1];
         assign w_prev    = sq_w_ff[k-1];
         assign rad_prev  = sq_rad_ff[k-1];
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
      end

      assign rem_t   = {rem_prev[REM_W-3:0], rad_prev[2*(ROOT_BITS-1-k)+1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign ge      = (rem_t >= trial);
      assign rem_in  = ge ? (rem_t - trial) : rem_t;
      assign root_in = {root_prev[ROOT_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ctl_ff[k] <= '0;
         end else if (adv) begin
            sq_ctl_ff[k] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_side_ff[k] <= side_prev;
            sq_w_ff[k]    <= w_prev;
            sq_rad_ff[k]  <= rad_prev;
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
         end
      end
   end

   // divide: stage 0 forms the rounded numerator, then one quotient bit per stage
   stage_ctl_type          dv_ctl_ff  [Q_BITS+1];
   logic [SIDE_W-1:0]      dv_side_ff [Q_BITS+1];
   logic [ROOT_BITS-1:0]   dv_len_ff  [Q_BITS+1];
   logic [NUM_BITS-1:0]    dv_num_ff  [Q_BITS+1][3];
   logic [DIV_W-1:0]       dv_rem_ff  [Q_BITS+1][3];
   logic [Q_BITS-1:0]      dv_q_ff    [Q_BITS+1][3];

   genvar j, ln;
   for (j = 0; j <= Q_BITS; j++) begin : g_div
      stage_ctl_type        ctl_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [ROOT_BITS-1:0] len_prev;

      if (j == 0) begin : g_first
         assign ctl_prev  = sq_ctl_ff[ROOT_BITS-1];
         assign side_prev = sq_side_ff[ROOT_BITS-1];
         assign len_prev  = sq_root_ff[ROOT_BITS-1];
      end else begin : g_next
         assign ctl_prev  = dv_ctl_ff[j-1];
         assign side_prev = dv_side_ff[j-1];
         assign len_prev  = dv_len_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[j] <= '0;
         end else if (adv) begin
            dv_ctl_ff[j] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[j] <= side_prev;
            dv_len_ff[j]  <= len_prev;
         end
      end

      for (ln = 0; ln < 3; ln++) begin : g_lane
         logic [NUM_BITS-1:0] num_in;
         logic [DIV_W-1:0]    rem_in;
         logic [Q_BITS-1:0]   q_in;

         if (j == 0) begin : g_num
            // |w| * 2^16 + floor(len / 2)
            assign num_in = NUM_BITS'({sq_w_ff[ROOT_BITS-1][ln*W_BITS +: W_BITS],
                                       COORD_FRAC'(0)})
                            + NUM_BITS'(len_prev >> 1);
            assign rem_in = DIV_W'(num_in >> Q_BITS);
            assign q_in   = '0;
         end else begin : g_step
            logic [DIV_W-1:0] t;
            logic             ge;
            assign t      = {dv_rem_ff[j-1][ln][DIV_W-2:0], dv_num_ff[j-1][ln][Q_BITS-j]};
            assign ge     = (t >= DIV_W'(len_prev));
            assign num_in = dv_num_ff[j-1][ln];
            assign rem_in = ge ? (t - DIV_W'(len_prev)) : t;
            assign q_in   = {dv_q_ff[j-1][ln][Q_BITS-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_num_ff[j][ln] <= num_in;
               dv_rem_ff[j][ln] <= rem_in;
               dv_q_ff[j][ln]   <= q_in;
            end
         end
      end
   end

   assign out_ctl  = dv_ctl_ff[Q_BITS];
   assign out_side = dv_side_ff[Q_BITS];
   assign out_q    = {dv_q_ff[Q_BITS][2], dv_q_ff[Q_BITS][1], dv_q_ff[Q_BITS][0]};

endmodule

// ===== sv/vertex_normal_affine_transform_unit.sv =====
// Top level: 3x3 affine vertex transform with pipelined normal renormalization.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: coord_x, coord_y, coord_z; tuser: opcode
//  rsp     | out | rsp_tvalid/tready    | tdata: result_x/y/z; tuser: item_kind, saturated
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// Fully pipelined: one transaction per cycle while the output is not stalled; the stages are
// matrix, scaling and squares, one square-root bit per stage, then the rounded numerator
// and one quotient bit per stage, then the output register.
// Positions ride the same pipeline so order is kept.
// Synchronous reset clears the valid bits and loads the identity matrix, zero translation.
// A stalled output freezes every stage; nothing is dropped or repeated.
module vertex_normal_affine_transform_unit #(
   parameter int COORD_WIDTH = vnat_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = vnat_pkg::COEF_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // coord_x, coord_y, coord_z, zero pad
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]              req_tdata,
   // opcode
   input  logic                                            req_tuser,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // result_x, result_y, result_z, zero pad
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]              rsp_tdata,
   // item_kind, saturated
   output logic [1:0]                                      rsp_tuser,
   input  logic                                            csr_we,
   input  logic [vnat_pkg::CSR_INDEX_W-1:0]                csr_index,
   input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] csr_wdata
);
   import vnat_pkg::*;

   localparam int DATA_W    = ((3*COORD_WIDTH+7)/8)*8;
   localparam int REG_W     = 3*COEF_WIDTH;
   localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
   localparam int PROD_W    = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_W     = PROD_W + 2;
   localparam int V_W       = SUM_W - COEF_FRAC;
   localparam int MSB_W     = $clog2(V_W);
   localparam int A_W       = (V_W > W_BITS) ? V_W : W_BITS;
   localparam int SIDE_W    = 3*V_W;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // configuration registers
   logic [REG_W-1:0]       row_ff   [3];
   logic [COORD_WIDTH-1:0] shift_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            row_ff[r]   <= REG_W'(1) << (r*COEF_WIDTH + COEF_FRAC);
            shift_ff[r] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_X:   row_ff[0]   <= REG_W'(csr_wdata);
            CSR_ROW_Y:   row_ff[1]   <= REG_W'(csr_wdata);
            CSR_ROW_Z:   row_ff[2]   <= REG_W'(csr_wdata);
            CSR_SHIFT_X: shift_ff[0] <= COORD_WIDTH'(csr_wdata);
            CSR_SHIFT_Y: shift_ff[1] <= COORD_WIDTH'(csr_wdata);
            CSR_SHIFT_Z: shift_ff[2] <= COORD_WIDTH'(csr_wdata);
            default: ;
         endcase
      end
   end

   // S1: nine products
   stage_ctl_type             s1_ctl_ff;
   logic signed [PROD_W-1:0]  s1_prod_ff [3][3];
   logic signed [PROD_W-1:0]  s1_prod_in [3][3];
   logic signed [COEF_WIDTH-1:0]  s1_coef [3][3];
   logic signed [COORD_WIDTH-1:0] s1_coord [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s1_coord[j] = $signed(req_tdata[j*COORD_WIDTH +: COORD_WIDTH]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            s1_coef[r][j]    = $signed(row_ff[r][j*COEF_WIDTH +: COEF_WIDTH]);
            s1_prod_in[r][j] = PROD_W'(s1_coef[r][j]) * PROD_W'(s1_coord[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= '{valid: req_tvalid, op: req_tuser, renorm: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
      end
   end

   // S2: row sums, translation for positions, round half up to Q22.16
   stage_ctl_type           s2_ctl_ff;
   logic signed [V_W-1:0]   s2_v_ff [3];
   logic signed [SUM_W-1:0] s2_sum [3];
   logic signed [V_W-1:0]   s2_v_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s2_sum[r] = SUM_W'(s1_prod_ff[r][0]) + SUM_W'(s1_prod_ff[r][1])
                   + SUM_W'(s1_prod_ff[r][2])
                   + ((s1_ctl_ff.op == OP_POSITION) ?
                      (SUM_W'($signed(shift_ff[r])) <<< COEF_FRAC) : SUM_W'(0))
                   + (SUM_W'(1) <<< (COEF_FRAC-1));
         s2_v_in[r] = s2_sum[r][SUM_W-1:COEF_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (adv) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_v_ff <= s2_v_in;
      end
   end

   // S3: magnitudes, largest magnitude, tiny-normal test
   stage_ctl_type         s3_ctl_ff;
   logic signed [V_W-1:0] s3_v_ff  [3];
   logic [A_W-1:0]        s3_a_ff  [3];
   logic [V_W-1:0]        s3_mx_ff;
   logic [V_W-1:0]        s3_a_in  [3];
   logic [V_W-1:0]        s3_mx_in;
   logic [7:0]            s3_small_sq;
   logic                  s3_small;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_a_in[i] = s2_v_ff[i][V_W-1] ? V_W'(-s2_v_ff[i]) : V_W'(s2_v_ff[i]);
      end
      s3_mx_in = s3_a_in[0];
      if (s3_a_in[1] > s3_mx_in) s3_mx_in = s3_a_in[1];
      if (s3_a_in[2] > s3_mx_in) s3_mx_in = s3_a_in[2];
      s3_small_sq = 8'(s3_a_in[0][SMALL_BITS-1:0]) * 8'(s3_a_in[0][SMALL_BITS-1:0])
                  + 8'(s3_a_in[1][SMALL_BITS-1:0]) * 8'(s3_a_in[1][SMALL_BITS-1:0])
                  + 8'(s3_a_in[2][SMALL_BITS-1:0]) * 8'(s3_a_in[2][SMALL_BITS-1:0]);
      s3_small = (s3_mx_in < V_W'(SMALL_LIMIT)) && (s3_small_sq < 8'(NORM_MIN_SQ));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (adv) begin
         s3_ctl_ff <= '{valid:  s2_ctl_ff.valid,
                        op:     s2_ctl_ff.op,
                        renorm: (s2_ctl_ff.op == OP_NORMAL) && !s3_small};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_v_ff  <= s2_v_ff;
         s3_mx_ff <= s3_mx_in;
         for (int i = 0; i < 3; i++) begin
            s3_a_ff[i] <= A_W'(s3_a_in[i]);
         end
      end
   end

   // S4: leading-one position of the largest magnitude
   stage_ctl_type         s4_ctl_ff;
   logic signed [V_W-1:0] s4_v_ff [3];
   logic [A_W-1:0]        s4_a_ff [3];
   logic [MSB_W-1:0]      s4_msb_ff;
   logic [MSB_W-1:0]      s4_msb_in;

   always_comb begin
      s4_msb_in = '0;
      for (int i = 0; i < V_W; i++) begin
         if (s3_mx_ff[i]) s4_msb_in = MSB_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (adv) begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_v_ff   <= s3_v_ff;
         s4_a_ff   <= s3_a_ff;
         s4_msb_ff <= s4_msb_in;
      end
   end

   // S5: common shift so the largest magnitude lands in [2^29, 2^30)
   stage_ctl_type         s5_ctl_ff;
   logic signed [V_W-1:0] s5_v_ff [3];
   logic [W_BITS-1:0]     s5_w_ff [3];
   logic [W_BITS-1:0]     s5_w_in [3];
   logic [A_W-1:0]        s5_shifted [3];
   logic [MSB_W-1:0]      s5_top;

   always_comb begin
      s5_top = MSB_W'(W_BITS-1);
      for (int i = 0; i < 3; i++) begin
         if (s4_msb_ff > s5_top) begin
            s5_shifted[i] = s4_a_ff[i] >> (s4_msb_ff - s5_top);
         end else begin
            s5_shifted[i] = s4_a_ff[i] << (s5_top - s4_msb_ff);
         end
         s5_w_in[i] = s5_shifted[i][W_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else if (adv) begin
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_v_ff <= s4_v_ff;
         s5_w_ff <= s5_w_in;
      end
   end

   // S6: squares
   stage_ctl_type           s6_ctl_ff;
   logic signed [V_W-1:0]   s6_v_ff  [3];
   logic [W_BITS-1:0]       s6_w_ff  [3];
   logic [2*W_BITS-1:0]     s6_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else if (adv) begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_v_ff <= s5_v_ff;
         s6_w_ff <= s5_w_ff;
         for (int i = 0; i < 3; i++) begin
            s6_sq_ff[i] <= (2*W_BITS)'(s5_w_ff[i]) * (2*W_BITS)'(s5_w_ff[i]);
         end
      end
   end

   // S7: sum of squares
   stage_ctl_type         s7_ctl_ff;
   logic [SIDE_W-1:0]     s7_side_ff;
   logic [3*W_BITS-1:0]   s7_w_ff;
   logic [SQ_BITS-1:0]    s7_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctl_ff <= '0;
      end else if (adv) begin
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_side_ff <= {s6_v_ff[2], s6_v_ff[1], s6_v_ff[0]};
         s7_w_ff    <= {s6_w_ff[2], s6_w_ff[1], s6_w_ff[0]};
         s7_sum_ff  <= SQ_BITS'(s6_sq_ff[0]) + SQ_BITS'(s6_sq_ff[1])
                     + SQ_BITS'(s6_sq_ff[2]);
      end
   end

   stage_ctl_type       nrm_ctl;
   logic [SIDE_W-1:0]   nrm_side;
   logic [3*Q_BITS-1:0] nrm_q;

   vnat_norm_pipe #(
      .SIDE_W (SIDE_W)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (s7_ctl_ff),
      .in_side  (s7_side_ff),
      .in_w     (s7_w_ff),
      .in_sq    (s7_sum_ff),
      .out_ctl  (nrm_ctl),
      .out_side (nrm_side),
      .out_q    (nrm_q)
   );

   // final: pick renormalized or transformed value, saturate
   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic                   rsp_sat_ff;
   logic [3*COORD_WIDTH-1:0] rsp_data_ff;
   logic [3*COORD_WIDTH-1:0] fin_data_in;
   logic                   fin_sat_in;
   logic signed [V_W-1:0]  fin_v   [3];
   logic signed [V_W-1:0]  fin_q   [3];
   logic signed [V_W-1:0]  fin_val [3];
   logic [V_W-COORD_WIDTH:0] fin_top [3];

   always_comb begin
      fin_sat_in  = 1'b0;
      fin_data_in = '0;
      for (int i = 0; i < 3; i++) begin
         fin_v[i]   = $signed(nrm_side[i*V_W +: V_W]);
         fin_q[i]   = $signed(V_W'(nrm_q[i*Q_BITS +: Q_BITS]));
         fin_val[i] = !nrm_ctl.renorm ? fin_v[i] :
                      (fin_v[i][V_W-1] ? -fin_q[i] : fin_q[i]);
         fin_top[i] = fin_val[i][V_W-1:COORD_WIDTH-1];
         if ((fin_top[i] == '0) || (fin_top[i] == '1)) begin
            fin_data_in[i*COORD_WIDTH +: COORD_WIDTH] = fin_val[i][COORD_WIDTH-1:0];
         end else begin
            fin_sat_in = 1'b1;
            fin_data_in[i*COORD_WIDTH +: COORD_WIDTH] =
               {fin_val[i][V_W-1], {(COORD_WIDTH-1){!fin_val[i][V_W-1]}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= nrm_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_kind_ff <= nrm_ctl.op;
         rsp_sat_ff  <= fin_sat_in;
         rsp_data_ff <= fin_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);
   assign rsp_tuser  = {rsp_sat_ff, rsp_kind_ff};

   // checks
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(nrm_ctl) && $stable(nrm_q))
      else $error("pipeline moved during output stall");

   if (COORD_WIDTH > COORD_FRAC + 1) begin : g_norm_check
      logic signed [COORD_WIDTH-1:0] chk_x;
      assign chk_x = $signed(rsp_data_ff[COORD_WIDTH-1:0]);
      a_normal_unit_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid_ff && (rsp_kind_ff == OP_NORMAL) |->
            !rsp_sat_ff && (chk_x <= NORM_ONE) && (chk_x >= -NORM_ONE))
         else $error("normal result outside unit range");
   end

endmodule
